>>> rtl/rmst_pkg.sv
package rmst_pkg;

    localparam int LEAVES     = 1024;
    localparam int VALUE_BITS = 16;
    localparam int NODES      = 2 * LEAVES;
    localparam int NODE_BITS  = $clog2(NODES);
    // walk pointers reach 2*LEAVES, one more bit than a node index
    localparam int CNT_BITS   = NODE_BITS + 1;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [NODE_BITS-1:0]  t_node;
    typedef logic [CNT_BITS-1:0]   t_cnt;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_QUERY
    } t_state;

    typedef struct packed {
        logic clear;     // zero one node per cycle
        logic load;      // word accepted this cycle
        logic upd_step;  // refresh one parent
        logic qry_step;  // fetch one level of the range
        logic qry_emit;  // last accumulate, drive result
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic load_upd;  // accepted word is an update inside the table
        logic load_qry;  // accepted word is a non-empty query
        logic upd_last;
        logic qry_more;
    } t_stat;

    function automatic t_value f_max(input t_value a, input t_value b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/rmst_ctrl.sv
module rmst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rmst_pkg::t_stat i_stat,
    output rmst_pkg::t_cmd  o_cmd,
    output logic          busy
);
    import rmst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_stat.load_upd)      n_state = ST_UPDATE;
                    else if (i_stat.load_qry) n_state = ST_QUERY;
                end
            end
            ST_UPDATE: begin
                if (i_stat.upd_last) n_state = ST_IDLE;
            end
            ST_QUERY: begin
                if (!i_stat.qry_more) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_UPDATE: begin
                o_cmd.upd_step = 1'b1;
            end
            ST_QUERY: begin
                o_cmd.qry_step = i_stat.qry_more;
                o_cmd.qry_emit = !i_stat.qry_more;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/rmst_dp.sv
module rmst_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rmst_pkg::t_cmd  i_cmd,
    output rmst_pkg::t_stat o_stat,
    input  logic            i_command,
    input  logic [9:0]      i_position,
    input  logic [15:0]     i_new_value,
    input  logic [10:0]     i_range_low,
    input  logic signed [10:0] i_range_high,
    output logic            o_strobe,
    output logic [15:0]     o_range_maximum
);
    import rmst_pkg::*;

    t_value mem [NODES];

    t_node  r_clr_addr;
    t_node  r_node;
    t_value r_cur;
    t_cnt   r_a;
    t_cnt   r_b;
    t_value r_rd0;
    t_value r_rd1;
    logic   r_v0;
    logic   r_v1;
    t_value r_acc;
    logic   r_strobe;
    logic [15:0] r_out;

    logic        pos_ok;
    t_node       leaf;
    t_value      val_in;
    logic [31:0] lo32;
    logic [31:0] hi32;
    logic [31:0] hi_c;
    logic        q_empty;
    t_node       parent;
    t_value      up_val;
    t_value      acc_n;
    t_cnt        b_dec;

    logic   we;
    t_node  waddr;
    t_value wdata;
    t_node  raddr0;
    t_node  raddr1;

    assign pos_ok  = 32'(i_position) < 32'(LEAVES);
    assign leaf    = NODE_BITS'(LEAVES) + NODE_BITS'(i_position);
    assign val_in  = VALUE_BITS'(i_new_value);
    assign lo32    = 32'(i_range_low);
    assign hi32    = 32'(i_range_high[9:0]);
    assign hi_c    = (hi32 >= 32'(LEAVES)) ? 32'(LEAVES - 1) : hi32;
    assign q_empty = i_range_high[10] || (lo32 > hi_c);

    assign parent = r_node >> 1;
    assign up_val = f_max(r_cur, r_rd0);
    assign acc_n  = f_max(r_acc, f_max(r_v0 ? r_rd0 : '0, r_v1 ? r_rd1 : '0));
    assign b_dec  = r_b - t_cnt'(1);

    assign o_stat.clr_last = (r_clr_addr == NODE_BITS'(NODES - 1));
    assign o_stat.load_upd = (i_command == CMD_UPDATE) && pos_ok;
    assign o_stat.load_qry = (i_command == CMD_QUERY) && !q_empty;
    assign o_stat.upd_last = (parent == t_node'(1));
    assign o_stat.qry_more = (r_a < r_b);

    // write / read port steering
    always_comb begin
        we     = 1'b0;
        waddr  = r_clr_addr;
        wdata  = '0;
        raddr0 = r_a[NODE_BITS-1:0];
        raddr1 = b_dec[NODE_BITS-1:0];
        if (i_cmd.clear) begin
            we = 1'b1;
        end else if (i_cmd.load) begin
            we     = o_stat.load_upd;
            waddr  = leaf;
            wdata  = val_in;
            raddr0 = leaf ^ t_node'(1);
        end else if (i_cmd.upd_step) begin
            we     = 1'b1;
            waddr  = parent;
            wdata  = up_val;
            raddr0 = parent ^ t_node'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd0 <= mem[raddr0];
        r_rd1 <= mem[raddr1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + t_node'(1);
            r_strobe <= (i_cmd.load && (i_command == CMD_QUERY) && q_empty) || i_cmd.qry_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_node <= leaf;
            r_cur  <= val_in;
            r_a    <= CNT_BITS'(32'(LEAVES) + lo32);
            r_b    <= CNT_BITS'(32'(LEAVES) + hi_c + 32'd1);
            r_acc  <= '0;
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_out  <= '0;
        end
        if (i_cmd.upd_step) begin
            r_node <= parent;
            r_cur  <= up_val;
        end
        // read data of this level lands next cycle, so accumulation lags the walk
        if (i_cmd.qry_step) begin
            r_v0  <= r_a[0];
            r_v1  <= r_b[0];
            r_a   <= (r_a + t_cnt'(r_a[0])) >> 1;
            r_b   <= (r_b - t_cnt'(r_b[0])) >> 1;
            r_acc <= acc_n;
        end
        if (i_cmd.qry_emit) begin
            r_out <= 16'(acc_n);
        end
    end

    assign o_strobe        = r_strobe;
    assign o_range_maximum = r_out;

endmodule

>>> rtl/range_max_segment_tree.sv
// Range-maximum table over 1024 positions of 16-bit values (max segment tree).
// Command channel: a word is taken at a rising edge with start high and busy low.
//   i_command = update: stores i_new_value at i_position, then refreshes one
//     tree level per cycle up to the root; busy stays high until the root is
//     refreshed. No result.
//   i_command = query: gives the maximum over [i_range_low, i_range_high].
//     Empty, inverted or negative ranges give 0 with o_strobe in the next
//     cycle and no busy time. Otherwise the walk fetches one level per cycle
//     (up to 11 levels), then a final step folds the last reads into the
//     result. o_strobe rises as busy falls.
// Result channel: o_range_maximum is valid only in the one cycle o_strobe is
//   high; the receiver cannot stall it.
// Rate is set by the single node memory: one level of the tree per cycle.
// Reset (i_rst_n low, synchronous): a clearing pass zeroes all 2048 nodes,
//   one per cycle; busy stays high until the pass ends.
module range_max_segment_tree (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  logic [9:0]         i_position,
    input  logic [15:0]        i_new_value,
    input  logic [10:0]        i_range_low,
    input  logic signed [10:0] i_range_high,
    output logic               o_strobe,
    output logic [15:0]        o_range_maximum
);
    import rmst_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rmst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    rmst_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_new_value     (i_new_value),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .o_strobe        (o_strobe),
        .o_range_maximum (o_range_maximum)
    );

endmodule

>>> rtl/rmst_checker.sv
module rmst_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_command,
    input logic signed [10:0] i_range_high,
    input logic               o_strobe,
    input logic [15:0]        o_range_maximum
);
    import rmst_pkg::*;

    // reset starts the clearing pass with no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_strobe)
        else $error("reset did not start clearing pass");

    // an update word never yields a result
    a_update_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_UPDATE) |=> !o_strobe)
        else $error("strobe after update");

    // negative upper bound: zero result in the next cycle
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_QUERY && i_range_high[10])
        |=> o_strobe && o_range_maximum == 16'd0)
        else $error("empty query result wrong");

    // an accepted update word raises busy for its walk
    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_UPDATE) |=> busy)
        else $error("update walk not busy");

endmodule

bind range_max_segment_tree rmst_checker u_rmst_checker (.*);

>>> verif/range_max_segment_tree_test.sv
module range_max_segment_tree_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rmst_pkg::*;

    localparam int RANDOM_WORDS = 1550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 30;

    // Keeps the leaf values flat and scans the range directly, so the
    // expected maximum does not depend on any tree layout.
    class range_max_scoreboard;
        t_value      leaf_val[LEAVES];
        t_value      pending_max[$];
        int unsigned errors;
        int unsigned updates;
        int unsigned queries;
        int unsigned empty_queries;
        int unsigned checked;

        function new();
            foreach (leaf_val[i]) leaf_val[i] = '0;
            errors        = 0;
            updates       = 0;
            queries       = 0;
            empty_queries = 0;
            checked       = 0;
        endfunction

        function void note_word(input logic cmd, input logic [9:0] pos, input t_value val,
                                input logic [10:0] lo, input logic signed [10:0] hi);
            int     bottom;
            int     top;
            int     i;
            t_value best;
            if (cmd == CMD_UPDATE) begin
                leaf_val[pos] = val;
                updates++;
            end else begin
                queries++;
                bottom = lo;
                top    = hi;
                if (top > LEAVES - 1) top = LEAVES - 1;
                best = '0;
                if (bottom > top) begin
                    empty_queries++;
                end else begin
                    for (i = bottom; i <= top; i++) begin
                        if (leaf_val[i] > best) best = leaf_val[i];
                    end
                end
                pending_max.push_back(best);
            end
        endfunction

        function void check_max(input logic [15:0] got);
            t_value want;
            if (pending_max.size() == 0) begin
                $display("%0t: unexpected result %h, no query pending", $time, got);
                errors++;
            end else begin
                want = pending_max.pop_front();
                checked++;
                if (got !== want) begin
                    $display("%0t: range max mismatch, expected %h, got %h", $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               start           = 1'b0;
    logic               busy;
    logic               i_command       = CMD_UPDATE;
    logic [9:0]         i_position      = '0;
    logic [15:0]        i_new_value     = '0;
    logic [10:0]        i_range_low     = '0;
    logic signed [10:0] i_range_high    = '0;
    logic               o_strobe;
    logic [15:0]        o_range_maximum;

    range_max_scoreboard board = new();
    int unsigned         cycles = 0;

    range_max_segment_tree DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_position      (i_position),
        .i_new_value     (i_new_value),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .o_strobe        (o_strobe),
        .o_range_maximum (o_range_maximum)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result check runs before the accept so a same-edge query cannot be popped early
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe !== 1'b0) board.check_max(o_range_maximum);
            if (start && busy === 1'b0) begin
                board.note_word(i_command, i_position, i_new_value, i_range_low, i_range_high);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, board.pending_max.size());
            $display("range_max_segment_tree_test: done, errors");
            $finish;
        end
    end

    // start stays high on return; the next word or a pause decides what follows
    task automatic send_word(input logic cmd, input logic [9:0] pos, input t_value val,
                             input logic [10:0] lo, input logic signed [10:0] hi);
        start        <= 1'b1;
        i_command    <= cmd;
        i_position   <= pos;
        i_new_value  <= val;
        i_range_low  <= lo;
        i_range_high <= hi;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic send_update(input logic [9:0] pos, input t_value val);
        send_word(CMD_UPDATE, pos, val, 11'($urandom), 11'($urandom));
    endtask

    task automatic send_query(input logic [10:0] lo, input logic signed [10:0] hi);
        send_word(CMD_QUERY, 10'($urandom), 16'($urandom), lo, hi);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        int                 sent;
        int                 burst;
        int                 kind;
        int                 a;
        int                 b;
        logic [9:0]         pos;
        t_value             val;
        logic [10:0]        lo;
        logic signed [10:0] hi;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, overwrite with a smaller value, empty ranges
        send_query(11'd0, 11'sd1023);
        send_update(10'd0, 16'hFFFF);
        send_update(10'd1023, 16'h0001);
        send_update(10'd512, 16'h8000);
        send_update(10'd511, 16'h7FFF);
        send_query(11'd0, 11'sd1023);
        send_query(11'd1, 11'sd1023);
        send_query(11'd1023, 11'sd1023);
        pause(3);
        send_query(11'd0, 11'sd0);
        send_query(11'd511, 11'sd512);
        send_query(11'd1, 11'sd511);
        send_update(10'd0, 16'h0003);
        send_query(11'd0, 11'sd1023);
        send_query(11'd0, 11'sd0);
        send_query(11'd10, 11'sd5);
        send_query(11'd0, -11'sd1);
        send_query(11'd0, -11'sd1024);
        pause(1);
        send_query(11'd1024, 11'sd1023);
        send_query(11'd2047, -11'sd1);
        send_query(11'd513, 11'sd1022);
        send_update(10'd1023, 16'h0000);
        send_query(11'd600, 11'sd1023);
        pause(5);

        // random: bursts of words, a hot region of 64 positions so values get overwritten
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                kind = $urandom_range(0, 99);
                if (kind < 45) begin
                    pos = $urandom_range(0, 1) ? 10'($urandom_range(0, 63)) : 10'($urandom);
                    case ($urandom_range(0, 9))
                        0:       val = '0;
                        1:       val = 16'hFFFF;
                        2, 3, 4: val = 16'($urandom_range(0, 255));
                        default: val = 16'($urandom);
                    endcase
                    send_update(pos, val);
                end else begin
                    if (kind < 60) begin
                        a  = $urandom_range(0, 63);
                        lo = 11'(a);
                        hi = 11'(a + $urandom_range(0, 8));
                    end else if (kind < 75) begin
                        a  = $urandom_range(0, LEAVES - 1);
                        b  = $urandom_range(0, LEAVES - 1);
                        lo = 11'((a < b) ? a : b);
                        hi = 11'((a < b) ? b : a);
                    end else if (kind < 82) begin
                        lo = $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(0, LEAVES - 1));
                        hi = 11'(LEAVES - 1);
                    end else if (kind < 88) begin
                        a  = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, LEAVES - 1);
                        lo = 11'(a);
                        hi = 11'(a);
                    end else begin
                        // empty words: negative high end, low end off the table, inverted
                        case ($urandom_range(0, 2))
                            0: begin
                                lo = 11'($urandom);
                                hi = 11'(-1 - int'($urandom_range(0, 1023)));
                            end
                            1: begin
                                lo = 11'($urandom_range(LEAVES, 2047));
                                hi = 11'($urandom_range(0, LEAVES - 1));
                            end
                            default: begin
                                a  = $urandom_range(1, LEAVES - 1);
                                lo = 11'(a);
                                hi = 11'($urandom_range(0, a - 1));
                            end
                        endcase
                    end
                    send_query(lo, hi);
                end
                sent++;
            end
            case ($urandom_range(0, 3))
                0:       pause(0);
                1:       pause($urandom_range(5, 30));
                default: pause($urandom_range(1, 4));
            endcase
        end
        start <= 1'b0;

        while (board.pending_max.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d updates and %0d queries (%0d empty or inverted)",
                 board.updates, board.queries, board.empty_queries);
        $display("%0d results checked, %0d failures", board.checked, board.errors);
        if (board.errors == 0) begin
            $display("range_max_segment_tree_test: done, clean");
        end else begin
            $display("range_max_segment_tree_test: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rmst_pkg.sv
rtl/rmst_ctrl.sv
rtl/rmst_dp.sv
rtl/range_max_segment_tree.sv
rtl/rmst_checker.sv
verif/range_max_segment_tree_test.sv
